FILE: src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/dht_pkg.sv
package dht_pkg;
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int MOD_W  = 11;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;

    localparam logic [1:0] FN_LOOKUP = 2'd0;
    localparam logic [1:0] FN_SET    = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } dht_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [VAL_W-1:0]  read_value;
        logic [SLOT_W-1:0] slot;
    } dht_out_t;
endpackage

FILE: src/double_hash_table_engine_unit.sv
// Double-hashing key/data table engine.
// From the accepting edge: key mod P in the bit-serial divider, then each probe reads and checks
// its slot, then S_DONE raises the result strobe; a hit or empty home slot ends at the first probe.
// One item at a time; busy stays high until the result strobe, and an unused function code
// goes straight from idle to S_DONE. Results cannot stall. A search makes at most P probes.
// Reset returns modulus to 1021 and clears the valid bits in one pass with busy high.
`include "assert_macros.svh"
module double_hash_table_engine_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  dht_pkg::dht_in_t                 cmd,
    output logic                             done,
    output dht_pkg::dht_out_t                result,
    input  logic                             cfg_we,
    input  logic [dht_pkg::MOD_W-1:0]        cfg_wdata
);
    import dht_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [MOD_W-1:0]  modulus_reg;
    logic [2:0]        state_reg, state_next;
    dht_in_t           cmd_reg;
    logic [MOD_W-1:0]  p_reg;
    logic [MOD_W-1:0]  pos_reg, pos_next;
    logic [MOD_W-1:0]  step_reg;
    logic [MOD_W-1:0]  left_reg, left_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic              valid_mem [SLOTS];
    logic [KEY_W-1:0]  key_mem [SLOTS];
    logic [VAL_W-1:0]  val_mem [SLOTS];
    logic [KEY_W-1:0]  rd_key_reg;
    logic [VAL_W-1:0]  rd_val_reg;
    logic              rd_valid_reg;
    dht_out_t          res_reg, res_next;
    logic              done_reg;
    logic              mod_go, mod_done;
    logic [MOD_W-1:0]  mod_rem;
    logic [MOD_W-1:0]  p_eff;
    logic [MOD_W:0]    pos_sum;
    logic              wr_en, wr_valid_set, wr_valid_clr, wr_key;
    logic [SLOT_W-1:0] addr;
    logic              vld_we, vld_wdata;
    logic [SLOT_W-1:0] vld_addr;

    // Effective table size: zero reads as one, larger than the table saturates.
    always_comb
    begin
        p_eff = modulus_reg;
        if (modulus_reg == '0)
            p_eff = MOD_W'(1);
        else if (modulus_reg > MOD_W'(SLOTS))
            p_eff = MOD_W'(SLOTS);
    end

    dht_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mod_go),
        .dividend  (cmd.key),
        .divisor   (p_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign addr    = pos_reg[SLOT_W-1:0];
    // Next probe: (pos + home) mod p; the step is the home slot itself, so a zero home never moves.
    assign pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        left_next    = left_reg;
        clr_next     = clr_reg;
        res_next     = res_reg;
        mod_go       = 1'b0;
        wr_en        = 1'b0;
        wr_key       = 1'b0;
        wr_valid_set = 1'b0;
        wr_valid_clr = 1'b0;
        vld_we       = 1'b0;
        vld_addr     = addr;
        vld_wdata    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                vld_we   = 1'b1;
                vld_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '{status: ST_NOT_FOUND, read_value: '0, slot: '0};
                    if (cmd.func == FN_LOOKUP || cmd.func == FN_SET
                        || cmd.func == FN_DELETE)
                        state_next = S_MOD;
                    else
                        state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    pos_next   = mod_rem;
                    left_next  = p_reg;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                if (!rd_valid_reg)
                begin
                    if (cmd_reg.func == FN_SET)
                    begin
                        wr_en        = 1'b1;
                        wr_key       = 1'b1;
                        wr_valid_set = 1'b1;
                        res_next     = '{status: ST_INSERTED, read_value: '0, slot: addr};
                    end
                end
                else if (rd_key_reg == cmd_reg.key)
                begin
                    res_next.status = ST_FOUND;
                    res_next.slot   = addr;
                    if (cmd_reg.func == FN_LOOKUP)
                        res_next.read_value = rd_val_reg;
                    else if (cmd_reg.func == FN_SET)
                        wr_en = 1'b1;
                    else
                        wr_valid_clr = 1'b1;
                end
                else if (left_reg == MOD_W'(1))
                begin
                    if (cmd_reg.func == FN_SET)
                        res_next.status = ST_FULL;
                end
                else
                begin
                    left_next = left_reg - 1'b1;
                    if (pos_sum >= {1'b0, p_reg})
                        pos_next = MOD_W'(pos_sum - {1'b0, p_reg});
                    else
                        pos_next = pos_sum[MOD_W-1:0];
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_IDLE && start
            && (cmd.func == FN_LOOKUP || cmd.func == FN_SET || cmd.func == FN_DELETE))
            mod_go = 1'b1;
        // A probe that inserts or deletes updates the slot's valid bit.
        if (wr_valid_set || wr_valid_clr)
        begin
            vld_we    = 1'b1;
            vld_wdata = wr_valid_set;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            modulus_reg <= MOD_W'(1021);
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= (state_reg == S_DONE);
            if (cfg_we)
                modulus_reg <= cfg_wdata;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
            p_reg   <= p_eff;
        end
        if (state_reg == S_MOD && mod_done)
            step_reg <= mod_rem;
        pos_reg      <= pos_next;
        left_reg     <= left_next;
        res_reg      <= res_next;
    end

    // Valid, key and data memories: one registered read, one write per cycle.
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_mem[addr];
        rd_key_reg   <= key_mem[addr];
        rd_val_reg   <= val_mem[addr];
        if (vld_we)
            valid_mem[vld_addr] <= vld_wdata;
        if (wr_en && wr_key)
            key_mem[addr] <= cmd_reg.key;
        if (wr_en)
            val_mem[addr] <= cmd_reg.value;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "item accepted but not busy")
    `CHK_IMPL(a_done_idle, clk, rst_n, done, !busy || $past(state_reg) == S_DONE,
        "result strobe out of place")
    `CHK_IMPL(a_slot_range, clk, rst_n, state_reg == S_CHECK, pos_reg < p_reg,
        "probe outside table")
endmodule

FILE: src/dht_mod_unit.sv
`include "assert_macros.svh"
// Bit-serial remainder: key mod p, one quotient bit per cycle.
module dht_mod_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [dht_pkg::KEY_W-1:0]   dividend,
    input  logic [dht_pkg::MOD_W-1:0]   divisor,
    output logic                        done,
    output logic [dht_pkg::MOD_W-1:0]   remainder
);
    import dht_pkg::*;

    localparam int CNT_W = $clog2(KEY_W + 1);

    logic [KEY_W-1:0] shift_reg, shift_next;
    logic [MOD_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [MOD_W:0]   trial;
    logic [MOD_W:0]   diff;

    // Shift in one dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        trial      = {rem_reg, shift_reg[KEY_W-1]};
        diff       = trial - {1'b0, divisor};
        if (go)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CNT_W'(KEY_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = diff[MOD_W-1:0];
            else
                rem_next = trial[MOD_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == CNT_W'(1));
    assign remainder = rem_next;

    `CHK_IMPL(a_rem_below, clk, rst_n, done, remainder < divisor, "remainder not below divisor")
    `CHK_NEXT(a_done_ends, clk, rst_n, done && !go, !busy_reg, "divider kept running")
    `CHK_IMPL(a_cnt_live, clk, rst_n, busy_reg, cnt_reg != '0, "divider busy with no bits left")
endmodule
